### design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies; the checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WBF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define WBF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define WBF_ASSERT_IMP(name, clk, rst, ante, cons)
`define WBF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

### design/wbf_pkg.sv
// shared constants, types and the cordic arctangent table for the
// world-to-body point transform; no dependencies
`default_nettype none

package wbf_pkg;

  localparam int CORDIC_STEPS = 30;
  // cos/sin in Q2.30 with two guard bits
  localparam int CS_W = 34;
  // residual angle, units of 2^-32 turn, with headroom
  localparam int Z_W = 33;
  localparam int TURN_W = 32;
  localparam int FRAC_BITS = 30;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [TURN_W-1:0] EIGHTH_TURN = 32'h2000_0000;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
    logic [TURN_W-1:0] r;
    case (idx)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051D;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2E;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2F9;
      5'd15: r = 32'h0000_517C;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A2F;
      5'd19: r = 32'h0000_0517;
      5'd20: r = 32'h0000_028B;
      5'd21: r = 32'h0000_0145;
      5'd22: r = 32'h0000_00A2;
      5'd23: r = 32'h0000_0051;
      5'd24: r = 32'h0000_0028;
      5'd25: r = 32'h0000_0014;
      5'd26: r = 32'h0000_000A;
      5'd27: r = 32'h0000_0005;
      5'd28: r = 32'h0000_0002;
      5'd29: r = 32'h0000_0001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/wbf_in_if.sv
// input channel: world point and robot pose, valid/ready handshake
// no dependencies
`default_nettype none

interface wbf_in_if #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] robot_x;
  logic signed [COORD_WIDTH-1:0] robot_y;
  logic signed [ANGLE_WIDTH-1:0] robot_heading;

  modport source (
    output valid, point_x, point_y, robot_x, robot_y, robot_heading,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, robot_x, robot_y, robot_heading,
    output ready
  );
endinterface

`default_nettype wire

### design/wbf_out_if.sv
// output channel: body-frame point and saturation flag, valid/ready handshake
// no dependencies
`default_nettype none

interface wbf_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] body_x;
  logic signed [COORD_WIDTH-1:0] body_y;
  logic saturated;

  modport source (
    output valid, body_x, body_y, saturated,
    input  ready
  );
  modport sink (
    input  valid, body_x, body_y, saturated,
    output ready
  );
endinterface

`default_nettype wire

### design/world_to_body_frame_point.sv
// World-to-body 2D point transform, top level.
// Input channel req carries a world point (Q16.16) and a robot pose: position
// (Q16.16) and heading (binary angle, 2^ANGLE_WIDTH units per turn). Output
// channel rsp carries the point in the robot frame, rounded half up and
// saturated, with a flag when either coordinate was clipped.
// Both channels use valid/ready; a beat moves when both are high.
// The pipeline runs through one entry stage, 30 cordic stages, partial
// products, product merge, sum with rounding, and saturation into the output
// register; rsp.valid rises when a beat reaches the output register.
// Throughput: one beat per cycle while rsp.ready does not stall the pipeline;
// the cordic stage chain and the split multipliers are fully pipelined.
// Stall: the whole pipeline holds while the output register is full and
// rsp.ready is low; req.ready drops in that cycle, so nothing is lost or
// repeated.
// Reset: rst clears every valid bit; no results are pending afterward.
// Depends on wbf_pkg, wbf_in_if, wbf_out_if, wbf_cordic, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module world_to_body_frame_point #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  wbf_in_if.sink     req,
  wbf_out_if.source  rsp
);
  import wbf_pkg::*;

  localparam int D_W  = COORD_WIDTH + 1;
  localparam int LO_W = (D_W + 1) / 2;
  localparam int HI_W = D_W - LO_W;
  localparam int PL_W = CS_W + LO_W + 1;
  localparam int PH_W = CS_W + HI_W;
  localparam int PR_W = CS_W + D_W;
  localparam int SM_W = PR_W + 2;
  localparam int PW   = 2 * D_W;

  localparam logic signed [COORD_WIDTH-1:0] OUT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic signed [SM_W-1:0] HALF =
    {{(SM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic adv;

  logic signed [D_W-1:0] dx_in;
  logic signed [D_W-1:0] dy_in;

  logic                   cs_valid;
  logic signed [CS_W-1:0] cos_v;
  logic signed [CS_W-1:0] sin_v;
  logic [PW-1:0]          cs_payload;

  logic signed [D_W-1:0]  dx_c;
  logic signed [D_W-1:0]  dy_c;
  logic signed [LO_W:0]   dx_lo;
  logic signed [LO_W:0]   dy_lo;
  logic signed [HI_W-1:0] dx_hi;
  logic signed [HI_W-1:0] dy_hi;

  logic signed [CS_W+LO_W:0]   p_cx_lo, p_sx_lo, p_cy_lo, p_sy_lo;
  logic signed [CS_W+HI_W-1:0] p_cx_hi, p_sx_hi, p_cy_hi, p_sy_hi;

  logic signed [PR_W-1:0] m_cx_next, m_sx_next, m_cy_next, m_sy_next;
  logic signed [PR_W-1:0] m_cx, m_sx, m_cy, m_sy;

  logic signed [SM_W-1:0] a_bx, a_by;
  logic signed [SM_W-1:0] sh_bx, sh_by;

  logic signed [COORD_WIDTH-1:0] o_bx_next, o_by_next;
  logic                          sat_x, sat_y;
  logic signed [COORD_WIDTH-1:0] o_bx, o_by;
  logic                          o_sat;

  logic v_p, v_m, v_a, v_o;

  // the pipeline moves whenever the output register is free or being read
  assign adv       = !v_o || rsp.ready;
  assign req.ready = adv;

  // exact offsets
  assign dx_in = D_W'(req.point_x) - D_W'(req.robot_x);
  assign dy_in = D_W'(req.point_y) - D_W'(req.robot_y);

  wbf_cordic #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .PW          (PW)
  ) u_cordic (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (req.valid),
    .heading     (req.robot_heading),
    .in_payload  ({dx_in, dy_in}),
    .out_valid   (cs_valid),
    .cos_v       (cos_v),
    .sin_v       (sin_v),
    .out_payload (cs_payload)
  );

  // split offsets into an unsigned low half and a signed high half
  assign dx_c  = $signed(cs_payload[PW-1:D_W]);
  assign dy_c  = $signed(cs_payload[D_W-1:0]);
  assign dx_lo = $signed({1'b0, dx_c[LO_W-1:0]});
  assign dy_lo = $signed({1'b0, dy_c[LO_W-1:0]});
  assign dx_hi = dx_c[D_W-1:LO_W];
  assign dy_hi = dy_c[D_W-1:LO_W];

  // partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cx_lo <= PL_W'(cos_v) * PL_W'(dx_lo);
      p_cx_hi <= PH_W'(cos_v) * PH_W'(dx_hi);
      p_sx_lo <= PL_W'(sin_v) * PL_W'(dx_lo);
      p_sx_hi <= PH_W'(sin_v) * PH_W'(dx_hi);
      p_cy_lo <= PL_W'(cos_v) * PL_W'(dy_lo);
      p_cy_hi <= PH_W'(cos_v) * PH_W'(dy_hi);
      p_sy_lo <= PL_W'(sin_v) * PL_W'(dy_lo);
      p_sy_hi <= PH_W'(sin_v) * PH_W'(dy_hi);
    end
  end

  // merge halves into full products
  always_comb begin
    m_cx_next = $signed({p_cx_hi, {LO_W{1'b0}}}) + PR_W'(p_cx_lo);
    m_sx_next = $signed({p_sx_hi, {LO_W{1'b0}}}) + PR_W'(p_sx_lo);
    m_cy_next = $signed({p_cy_hi, {LO_W{1'b0}}}) + PR_W'(p_cy_lo);
    m_sy_next = $signed({p_sy_hi, {LO_W{1'b0}}}) + PR_W'(p_sy_lo);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_cx <= m_cx_next;
      m_sx <= m_sx_next;
      m_cy <= m_cy_next;
      m_sy <= m_sy_next;
    end
  end

  // rotate by minus heading, add the rounding half
  always_ff @(posedge clk) begin
    if (adv) begin
      a_bx <= SM_W'(m_cx) + SM_W'(m_sy) + HALF;
      a_by <= SM_W'(m_cy) - SM_W'(m_sx) + HALF;
    end
  end

  // drop the fraction and clip to the coordinate range
  assign sh_bx = a_bx >>> FRAC_BITS;
  assign sh_by = a_by >>> FRAC_BITS;

  always_comb begin
    sat_x     = 1'b1;
    sat_y     = 1'b1;
    if (sh_bx > SM_W'(OUT_MAX)) begin
      o_bx_next = OUT_MAX;
    end else if (sh_bx < SM_W'(OUT_MIN)) begin
      o_bx_next = OUT_MIN;
    end else begin
      o_bx_next = sh_bx[COORD_WIDTH-1:0];
      sat_x     = 1'b0;
    end
    if (sh_by > SM_W'(OUT_MAX)) begin
      o_by_next = OUT_MAX;
    end else if (sh_by < SM_W'(OUT_MIN)) begin
      o_by_next = OUT_MIN;
    end else begin
      o_by_next = sh_by[COORD_WIDTH-1:0];
      sat_y     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_bx  <= o_bx_next;
      o_by  <= o_by_next;
      o_sat <= sat_x || sat_y;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
      v_m <= 1'b0;
      v_a <= 1'b0;
      v_o <= 1'b0;
    end else if (adv) begin
      v_p <= cs_valid;
      v_m <= v_p;
      v_a <= v_m;
      v_o <= v_a;
    end
  end

  assign rsp.valid     = v_o;
  assign rsp.body_x    = o_bx;
  assign rsp.body_y    = o_by;
  assign rsp.saturated = o_sat;

  // checks
  `WBF_ASSERT_IMP(a_sat_at_bound, clk, rst, rsp.valid && rsp.saturated,
    rsp.body_x == OUT_MAX || rsp.body_x == OUT_MIN ||
    rsp.body_y == OUT_MAX || rsp.body_y == OUT_MIN)
  `WBF_ASSERT_NXT(a_cordic_holds, clk, rst, cs_valid && !adv, cs_valid)
  `WBF_ASSERT_NXT(a_sum_reaches_out, clk, rst, v_a && adv, v_o)
  `WBF_ASSERT_IMP(a_empty_after_reset, clk, rst, $past(rst), !rsp.valid)

endmodule

`default_nettype wire

### design/wbf_cordic.sv
// pipelined rotation-mode cordic: heading to cos/sin in Q2.30, one stage per
// micro-rotation, side payload carried alongside; uses wbf_pkg
`default_nettype none

module wbf_cordic #(
  parameter int ANGLE_WIDTH = 16,
  parameter int PW = 66
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [ANGLE_WIDTH-1:0]          heading,
  input  logic [PW-1:0]                   in_payload,
  output logic                            out_valid,
  output logic signed [wbf_pkg::CS_W-1:0] cos_v,
  output logic signed [wbf_pkg::CS_W-1:0] sin_v,
  output logic [PW-1:0]                   out_payload
);
  import wbf_pkg::*;

  logic [TURN_W-1:0] turn;

  logic signed [CS_W-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CS_W-1:0] y_r [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r [0:CORDIC_STEPS];
  quad_t                  q_r [0:CORDIC_STEPS];
  logic [PW-1:0]          p_r [0:CORDIC_STEPS];
  logic                   v_r [0:CORDIC_STEPS];

  // heading as a turn fraction, shifted by an eighth so the quadrant splits off
  assign turn = {heading, {(TURN_W-ANGLE_WIDTH){1'b0}}} + EIGHTH_TURN;

  // entry stage
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= $signed({{(Z_W-FRAC_BITS){1'b0}}, turn[FRAC_BITS-1:0]})
                - $signed({1'b0, EIGHTH_TURN});
      q_r[0] <= quad_t'(turn[TURN_W-1 -: 2]);
      p_r[0] <= in_payload;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= CORDIC_STEPS; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= CORDIC_STEPS; i++) v_r[i] <= v_r[i-1];
    end
  end

  // micro-rotation stages
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    logic signed [Z_W-1:0]  at;

    assign xs = x_r[g] >>> g;
    assign ys = y_r[g] >>> g;
    assign at = $signed({1'b0, atan_turn(5'(g))});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[g][Z_W-1]) begin
          x_r[g+1] <= x_r[g] - ys;
          y_r[g+1] <= y_r[g] + xs;
          z_r[g+1] <= z_r[g] - at;
        end else begin
          x_r[g+1] <= x_r[g] + ys;
          y_r[g+1] <= y_r[g] - xs;
          z_r[g+1] <= z_r[g] + at;
        end
        q_r[g+1] <= q_r[g];
        p_r[g+1] <= p_r[g];
      end
    end
  end

  // quadrant applied by swap and negate
  always_comb begin
    case (q_r[CORDIC_STEPS])
      QUAD_0: begin
        cos_v = x_r[CORDIC_STEPS];
        sin_v = y_r[CORDIC_STEPS];
      end
      QUAD_1: begin
        cos_v = -y_r[CORDIC_STEPS];
        sin_v = x_r[CORDIC_STEPS];
      end
      QUAD_2: begin
        cos_v = -x_r[CORDIC_STEPS];
        sin_v = -y_r[CORDIC_STEPS];
      end
      default: begin
        cos_v = y_r[CORDIC_STEPS];
        sin_v = -x_r[CORDIC_STEPS];
      end
    endcase
  end

  assign out_valid   = v_r[CORDIC_STEPS];
  assign out_payload = p_r[CORDIC_STEPS];

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for world_to_body_frame_point: random and directed
// poses with random idling on both channels; needs wbf_pkg, wbf_in_if, wbf_out_if and the DUT

module testbench;
  import wbf_pkg::*;

  localparam int CW = 32;
  localparam int AW = 16;
  localparam int ACC_W = 96;
  localparam int RANDOM_POSES = 1200;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_MAX = 10;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] robot_x;
    logic signed [CW-1:0] robot_y;
    logic signed [AW-1:0] robot_heading;
  } world_pose_t;

  typedef struct {
    logic signed [CW-1:0] body_x;
    logic signed [CW-1:0] body_y;
    logic saturated;
  } body_point_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051, 32'h0000_0028,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0002, 32'h0000_0001
  };

  localparam acc_t COORD_MAX = (acc_t'(1) <<< (CW - 1)) - acc_t'(1);
  localparam acc_t COORD_MIN = -(acc_t'(1) <<< (CW - 1));

  logic clk;
  logic rst;

  wbf_in_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) in_ch ();
  wbf_out_if #(.COORD_WIDTH(CW)) out_ch ();

  world_to_body_frame_point #(
    .COORD_WIDTH(CW),
    .ANGLE_WIDTH(AW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(in_ch),
    .rsp(out_ch)
  );

  world_pose_t pose_pending_q[$];
  body_point_t body_expect_q[$];
  world_pose_t shown_pose;
  int send_wait;
  int take_wait;
  int sent_count;
  int got_count;
  int mismatch_count;
  int quiet_cycles;

  // round half up by 2^30 and clip to the coordinate range
  function automatic logic signed [CW-1:0] round_clip(acc_t v, output logic clipped);
    acc_t r;
    r = (v + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    clipped = 1'b0;
    if (r > COORD_MAX) begin
      clipped = 1'b1;
      r = COORD_MAX;
    end else if (r < COORD_MIN) begin
      clipped = 1'b1;
      r = COORD_MIN;
    end
    return r[CW-1:0];
  endfunction

  // offset from the robot, rotated by minus the heading
  function automatic body_point_t transform_point(world_pose_t w);
    logic [TURN_W-1:0] turn;
    quad_t quad;
    longint signed x, y, z, xs, ys, cos_v, sin_v;
    logic signed [CW:0] dx, dy;
    logic clip_x, clip_y;
    body_point_t r;
    turn = {w.robot_heading, {(TURN_W - AW){1'b0}}} + EIGHTH_TURN;
    quad = quad_t'(turn[TURN_W-1:TURN_W-2]);
    z = longint'(turn[TURN_W-3:0]) - longint'(EIGHTH_TURN);
    x = longint'(CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    // put the quadrant back by swapping and negating
    case (quad)
      QUAD_0: begin
        cos_v = x;
        sin_v = y;
      end
      QUAD_1: begin
        cos_v = -y;
        sin_v = x;
      end
      QUAD_2: begin
        cos_v = -x;
        sin_v = -y;
      end
      default: begin
        cos_v = y;
        sin_v = -x;
      end
    endcase
    dx = (CW + 1)'(w.point_x) - (CW + 1)'(w.robot_x);
    dy = (CW + 1)'(w.point_y) - (CW + 1)'(w.robot_y);
    r.body_x = round_clip(acc_t'(cos_v) * acc_t'(dx) + acc_t'(sin_v) * acc_t'(dy), clip_x);
    r.body_y = round_clip(acc_t'(cos_v) * acc_t'(dy) - acc_t'(sin_v) * acc_t'(dx), clip_y);
    r.saturated = clip_x | clip_y;
    return r;
  endfunction

  // idle cycles before the next beat; every fourth stretch of 100 runs flat out
  function automatic int pause_cycles(int seq);
    if ((seq / 100) % 4 == 3)
      return 0;
    return $urandom_range(0, 4);
  endfunction

  // random coordinate within +/- 2^(bits-1)
  function automatic logic signed [CW-1:0] rand_coord(int bits);
    logic signed [CW-1:0] r;
    r = $urandom;
    return r >>> (CW - bits);
  endfunction

  task automatic queue_pose(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic signed [CW-1:0] rx, logic signed [CW-1:0] ry,
                            logic signed [AW-1:0] hd);
    world_pose_t p;
    p.point_x = px;
    p.point_y = py;
    p.robot_x = rx;
    p.robot_y = ry;
    p.robot_heading = hd;
    pose_pending_q.push_back(p);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver: one pose per beat, random gaps between beats
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_wait = pause_cycles(0);
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        body_expect_q.push_back(transform_point(shown_pose));
        sent_count++;
        send_wait = pause_cycles(sent_count);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (pose_pending_q.size() != 0) begin
          shown_pose = pose_pending_q.pop_front();
          in_ch.point_x <= shown_pose.point_x;
          in_ch.point_y <= shown_pose.point_y;
          in_ch.robot_x <= shown_pose.robot_x;
          in_ch.robot_y <= shown_pose.robot_y;
          in_ch.robot_heading <= shown_pose.robot_heading;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: compare each beat with the oldest expected point
  always @(posedge clk) begin
    body_point_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      take_wait = pause_cycles(0);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_count++;
        if (body_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result %0d arrived with nothing expected", got_count);
        end else begin
          want = body_expect_q.pop_front();
          if (out_ch.body_x !== want.body_x || out_ch.body_y !== want.body_y ||
              out_ch.saturated !== want.saturated) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("result %0d: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
                       got_count, want.body_x, want.body_y, want.saturated,
                       out_ch.body_x, out_ch.body_y, out_ch.saturated);
          end
        end
        take_wait = pause_cycles(got_count);
      end
      if (take_wait > 0) begin
        take_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** world_to_body_frame_point: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int kind;
    logic signed [CW-1:0] px, py;
    logic signed [AW-1:0] hd;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.robot_x = '0;
    in_ch.robot_y = '0;
    in_ch.robot_heading = '0;
    out_ch.ready = 1'b0;
    sent_count = 0;
    got_count = 0;
    mismatch_count = 0;
    quiet_cycles = 0;

    // directed: identity, zero offset, quadrant headings, extremes, overflow
    queue_pose('0, '0, '0, '0, '0);
    queue_pose(32'sh0001_0000, 32'sh0002_0000, '0, '0, '0);
    queue_pose(32'sh1234_5678, -32'sh0765_4321, 32'sh1234_5678, -32'sh0765_4321, 16'sh1234);
    queue_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh2000);
    queue_pose(32'sh0003_0000, 32'sh0001_0000, '0, '0, 16'sh4000);
    queue_pose(32'sh0003_0000, 32'sh0001_0000, '0, '0, -16'sh4000);
    queue_pose(32'sh0003_0000, 32'sh0001_0000, '0, '0, -16'sh8000);
    queue_pose(32'sh0003_0000, 32'sh0001_0000, '0, '0, 16'sh7FFF);
    queue_pose(32'sh0003_0000, 32'sh0001_0000, '0, '0, 16'sh2000);
    queue_pose(32'sh0003_0000, 32'sh0001_0000, '0, '0, -16'sh2000);
    queue_pose(32'sh0003_0000, 32'sh0001_0000, '0, '0, 16'sh0001);
    queue_pose(32'sh7FFF_FFFF, '0, '0, '0, '0);
    queue_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000, '0);
    queue_pose(-32'sh8000_0000, -32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
    queue_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0, 16'sh2000);
    queue_pose(-32'sh8000_0000, '0, '0, '0, -16'sh8000);
    queue_pose(-32'sh8000_0000, '0, '0, '0, 16'sh4000);
    queue_pose('0, -32'sh8000_0000, '0, '0, '0);
    queue_pose(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 16'sh7FFF);
    queue_pose(-1, -1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -16'sh8000);
    queue_pose(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 16'sh5555);

    // random: full range, small values, zero offset, near overflow, near
    // a heading that is a multiple of a sixteenth turn
    for (int n = 0; n < RANDOM_POSES; n++) begin
      kind = $urandom_range(0, 9);
      hd = AW'($urandom_range(0, (1 << AW) - 1));
      if (kind <= 2) begin
        queue_pose($urandom, $urandom, $urandom, $urandom, hd);
      end else if (kind <= 5) begin
        queue_pose(rand_coord(21), rand_coord(21), rand_coord(21), rand_coord(21), hd);
      end else if (kind == 6) begin
        px = $urandom;
        py = $urandom;
        queue_pose(px, py, px, py, hd);
      end else if (kind == 7) begin
        px = $urandom;
        py = $urandom;
        queue_pose(px, py, (px ^ 32'sh8000_0000) + rand_coord(12),
                   (py ^ 32'sh8000_0000) + rand_coord(12), hd);
      end else begin
        hd = AW'($urandom_range(0, 15) * 4096) + AW'($urandom_range(0, 4)) - AW'(2);
        queue_pose(rand_coord(28), rand_coord(28), rand_coord(28), rand_coord(28), hd);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain, then allow for any stray result
    while (pose_pending_q.size() != 0 || in_ch.valid || body_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && body_expect_q.size() == 0) begin
      $display("** world_to_body_frame_point: PASSED **");
    end else begin
      $display("** world_to_body_frame_point: FAILED **");
    end
    $finish;
  end

endmodule

### world_to_body_frame_point.f
+incdir+design
design/wbf_pkg.sv
design/wbf_in_if.sv
design/wbf_out_if.sv
design/wbf_cordic.sv
design/world_to_body_frame_point.sv
test/testbench.sv
